>>> rtl/adcm_pkg.sv
package adcm_pkg;

	// deadzone and smoothing are limited to 0.99 in Q0.16
	localparam logic [15:0] FRAC_MAX = 16'd64880;

	// configuration register indexes
	localparam logic [2:0] REG_INPUT_LOW   = 3'd0;
	localparam logic [2:0] REG_INPUT_HIGH  = 3'd1;
	localparam logic [2:0] REG_OUTPUT_LOW  = 3'd2;
	localparam logic [2:0] REG_OUTPUT_HIGH = 3'd3;
	localparam logic [2:0] REG_DEAD_BAND   = 3'd4;
	localparam logic [2:0] REG_GAIN        = 3'd5;
	localparam logic [2:0] REG_SMOOTHING   = 3'd6;
	localparam logic [2:0] REG_REVERSE     = 3'd7;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_WRITE  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] sample;
		logic [7:0]         index;
		logic signed [17:0] value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] input_low;
		logic signed [15:0] input_high;
		logic signed [15:0] output_low;
		logic signed [15:0] output_high;
		logic [15:0]        dead_band;
		logic [15:0]        gain;
		logic [15:0]        smoothing;
		logic               reverse;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FMUL_A,
		ST_FMUL_B,
		ST_FSUM,
		ST_FRND,
		ST_NORM,
		ST_NUM,
		ST_TMUL,
		ST_DIV,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_INTERP,
		ST_GAIN,
		ST_CLAMP,
		ST_MAP,
		ST_OUT
	} state_t;

endpackage

>>> rtl/adcm_ram.sv
module adcm_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/adcm_queue.sv
module adcm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  adcm_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output adcm_pkg::item_t head,
	output logic            empty
);

	adcm_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/adcm_front.sv
module adcm_front (
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic signed [15:0] sample_value,
	input  logic [7:0]         table_index,
	input  logic signed [17:0] table_value,
	input  adcm_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               q_push,
	output adcm_pkg::item_t    q_item
);

	logic accept;
	logic range_ok;

	// empty input range: sample is swallowed here, filter untouched
	assign range_ok = (cfg.input_high > cfg.input_low);
	assign full     = q_full;
	assign accept   = push && !q_full;
	assign q_push   = accept && (kind || range_ok);

	assign q_item.op     = kind ? adcm_pkg::OP_WRITE : adcm_pkg::OP_SAMPLE;
	assign q_item.sample = sample_value;
	assign q_item.index  = table_index;
	assign q_item.value  = table_value;

endmodule

>>> rtl/adcm_back.sv
module adcm_back #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  adcm_pkg::cfg_t     cfg,
	input  logic               q_empty,
	input  adcm_pkg::item_t    q_head,
	output logic               q_pop,
	output logic               res_empty,
	input  logic               res_pop,
	output logic signed [15:0] axis_out
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int QW = IW + 16;
	localparam int TW = 32 + IW;
	localparam int CW = $clog2(QW);
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
	localparam logic signed [54:0] ONE42 = 55'sd4398046511104;

	adcm_pkg::state_t state_q, state_d;

	logic signed [31:0] level_q;
	logic               awaiting_q;
	logic signed [16:0] v_q;
	logic signed [34:0] m1_q;
	logic signed [48:0] m2_q;
	logic               neg_q;
	logic [19:0]        ad_q;
	logic [31:0]        den_q;
	logic signed [37:0] num_q;
	logic [31:0]        rem_q;
	logic [QW-1:0]      sh_q;
	logic [QW-1:0]      quo_q;
	logic [CW-1:0]      cnt_q;
	logic [IW-1:0]      i0_q;
	logic [15:0]        f_q;
	logic signed [17:0] t0_q;
	logic signed [17:0] t1_q;
	logic signed [36:0] c_q;
	logic signed [53:0] p_q;
	logic [43:0]        pu_q;
	logic signed [61:0] q_q;
	logic               out_valid_q;
	logic signed [15:0] out_q;

	logic               ram_we;
	logic [IW-1:0]      ram_raddr;
	logic signed [17:0] ram_rdata;
	logic [IW+7:0]      idx_ext;
	logic               wr_in_range;
	logic               out_load;

	logic [15:0]        s_eff;
	logic [15:0]        z_eff;
	logic signed [16:0] range_c;
	logic [15:0]        range_u;
	logic signed [17:0] oms;
	logic signed [34:0] m1_c;
	logic signed [48:0] m2_c;
	logic signed [51:0] acc_c;
	logic [32:0]        lvl_abs;
	logic [32:0]        lvl_rnd;
	logic [16:0]        lvl_mag;
	logic signed [19:0] diff_c;
	logic signed [19:0] d_c;
	logic [31:0]        zr_c;
	logic signed [37:0] num_c;
	logic signed [37:0] den_ext;
	logic [TW-1:0]      t_c;
	logic [32:0]        trial;
	logic               ge;
	logic [32:0]        rem_n;
	logic [QW-1:0]      quo_n;
	logic [IW-1:0]      i1_c;
	logic signed [18:0] dt_c;
	logic signed [35:0] fp_c;
	logic signed [36:0] c_c;
	logic signed [53:0] p_c;
	logic signed [54:0] pn_c;
	logic signed [43:0] pc_c;
	logic signed [43:0] pr_c;
	logic signed [16:0] orng;
	logic signed [61:0] q_c;
	logic [61:0]        qa_c;
	logic [62:0]        rs_c;
	logic [19:0]        rr_c;
	logic signed [20:0] r_c;
	logic signed [20:0] o_c;
	logic signed [15:0] o_sat;

	assign s_eff = (cfg.smoothing > adcm_pkg::FRAC_MAX) ? adcm_pkg::FRAC_MAX : cfg.smoothing;
	assign z_eff = (cfg.dead_band > adcm_pkg::FRAC_MAX) ? adcm_pkg::FRAC_MAX : cfg.dead_band;
	assign range_c = {cfg.input_high[15], cfg.input_high} - {cfg.input_low[15], cfg.input_low};
	assign range_u = range_c[15:0];

	// filter
	assign oms     = 18'sd65536 - $signed({2'b00, s_eff});
	assign m1_c    = oms * v_q;
	assign m2_c    = $signed({1'b0, s_eff}) * level_q;
	assign acc_c   = {m1_q[34], m1_q, 16'h0000} + {{3{m2_q[48]}}, m2_q} + 52'sd32768;
	assign lvl_abs = level_q[31] ? -{level_q[31], level_q} : {level_q[31], level_q};
	assign lvl_rnd = lvl_abs + 33'd32768;
	assign lvl_mag = lvl_rnd[32:16];

	// normalise and deadzone
	assign diff_c  = {{3{v_q[16]}}, v_q} - {{4{cfg.input_low[15]}}, cfg.input_low};
	assign d_c     = (diff_c <<< 1) - {{3{range_c[16]}}, range_c};
	assign zr_c    = {16'h0000, z_eff} * {16'h0000, range_u};
	assign num_c   = $signed({2'b00, ad_q, 16'h0000}) - $signed({6'b000000, zr_c});
	assign den_ext = $signed({6'b000000, den_q});

	// table position, one quotient bit a cycle
	assign t_c   = TW'(num_q[31:0]) * TW'(TABLE_DEPTH - 1);
	assign trial = {rem_q, sh_q[QW-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign rem_n = ge ? (trial - {1'b0, den_q}) : trial;
	assign quo_n = {quo_q[QW-2:0], ge};
	assign i1_c  = (i0_q == LAST) ? LAST : (i0_q + 1'b1);

	// interpolation, gain, clamp
	assign dt_c = {t1_q[17], t1_q} - {t0_q[17], t0_q};
	assign fp_c = $signed({1'b0, f_q}) * dt_c;
	assign c_c  = {{3{t0_q[17]}}, t0_q, 16'h0000} + {fp_c[35], fp_c};
	assign p_c  = c_q * $signed({1'b0, cfg.gain});
	assign pn_c = neg_q ? -{p_q[53], p_q} : {p_q[53], p_q};

	always_comb begin
		if (pn_c > ONE42) begin
			pc_c = ONE42[43:0];
		end else if (pn_c < -ONE42) begin
			pc_c = -(ONE42[43:0]);
		end else begin
			pc_c = pn_c[43:0];
		end
	end

	assign pr_c = cfg.reverse ? -pc_c : pc_c;

	// output mapping
	assign orng = {cfg.output_high[15], cfg.output_high} - {cfg.output_low[15], cfg.output_low};
	assign q_c  = $signed({1'b0, pu_q}) * orng;
	assign qa_c = q_q[61] ? -q_q : q_q;
	assign rs_c = {1'b0, qa_c} + (63'd1 << 42);
	assign rr_c = rs_c[62:43];
	assign r_c  = q_q[61] ? -{1'b0, rr_c} : {1'b0, rr_c};
	assign o_c  = {{5{cfg.output_low[15]}}, cfg.output_low} + r_c;

	always_comb begin
		if (o_c > 21'sd32767) begin
			o_sat = 16'sh7fff;
		end else if (o_c < -21'sd32768) begin
			o_sat = 16'sh8000;
		end else begin
			o_sat = o_c[15:0];
		end
	end

	assign idx_ext     = {{IW{1'b0}}, q_head.index};
	assign wr_in_range = (idx_ext < (IW+8)'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = i0_q;
		out_load  = 1'b0;
		unique case (state_q)
			adcm_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_head.op == adcm_pkg::OP_WRITE) begin
						ram_we = wr_in_range;
					end else if (s_eff == 16'h0000 || awaiting_q) begin
						state_d = adcm_pkg::ST_NORM;
					end else begin
						state_d = adcm_pkg::ST_FMUL_A;
					end
				end
			end
			adcm_pkg::ST_FMUL_A: state_d = adcm_pkg::ST_FMUL_B;
			adcm_pkg::ST_FMUL_B: state_d = adcm_pkg::ST_FSUM;
			adcm_pkg::ST_FSUM:   state_d = adcm_pkg::ST_FRND;
			adcm_pkg::ST_FRND:   state_d = adcm_pkg::ST_NORM;
			adcm_pkg::ST_NORM:   state_d = adcm_pkg::ST_NUM;
			adcm_pkg::ST_NUM: begin
				if (num_c <= 38'sd0 || num_c >= den_ext) begin
					state_d = adcm_pkg::ST_RD0;
				end else begin
					state_d = adcm_pkg::ST_TMUL;
				end
			end
			adcm_pkg::ST_TMUL: state_d = adcm_pkg::ST_DIV;
			adcm_pkg::ST_DIV: begin
				if (cnt_q == CW'(QW - 1)) begin
					state_d = adcm_pkg::ST_RD0;
				end
			end
			adcm_pkg::ST_RD0: begin
				ram_raddr = i0_q;
				state_d   = adcm_pkg::ST_RD1;
			end
			adcm_pkg::ST_RD1: begin
				ram_raddr = i1_c;
				state_d   = adcm_pkg::ST_RD2;
			end
			adcm_pkg::ST_RD2:    state_d = adcm_pkg::ST_INTERP;
			adcm_pkg::ST_INTERP: state_d = adcm_pkg::ST_GAIN;
			adcm_pkg::ST_GAIN:   state_d = adcm_pkg::ST_CLAMP;
			adcm_pkg::ST_CLAMP:  state_d = adcm_pkg::ST_MAP;
			adcm_pkg::ST_MAP:    state_d = adcm_pkg::ST_OUT;
			adcm_pkg::ST_OUT: begin
				if (!out_valid_q || res_pop) begin
					out_load = 1'b1;
					state_d  = adcm_pkg::ST_IDLE;
				end
			end
			default: state_d = adcm_pkg::ST_IDLE;
		endcase
	end

	// filter state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 32'sd0;
			awaiting_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == adcm_pkg::ST_IDLE && !q_empty && q_head.op == adcm_pkg::OP_SAMPLE
				&& s_eff != 16'h0000 && awaiting_q) begin
				level_q    <= {q_head.sample, 16'h0000};
				awaiting_q <= 1'b0;
			end else if (state_q == adcm_pkg::ST_FSUM) begin
				level_q <= acc_c[47:16];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			adcm_pkg::ST_IDLE: begin
				v_q <= {q_head.sample[15], q_head.sample};
			end
			adcm_pkg::ST_FMUL_A: m1_q <= m1_c;
			adcm_pkg::ST_FMUL_B: m2_q <= m2_c;
			adcm_pkg::ST_FRND: begin
				v_q <= level_q[31] ? -$signed(lvl_mag) : $signed(lvl_mag);
			end
			adcm_pkg::ST_NORM: begin
				neg_q <= d_c[19];
				ad_q  <= d_c[19] ? -d_c : d_c;
				den_q <= 32'({16'h0000, range_u} * (32'd65536 - {16'h0000, z_eff}));
			end
			adcm_pkg::ST_NUM: begin
				num_q <= num_c;
				f_q   <= 16'h0000;
				if (num_c <= 38'sd0) begin
					i0_q <= '0;
				end else begin
					i0_q <= LAST;
				end
			end
			adcm_pkg::ST_TMUL: begin
				rem_q <= t_c[TW-1:IW];
				sh_q  <= {t_c[IW-1:0], 16'h0000};
				quo_q <= '0;
				cnt_q <= '0;
			end
			adcm_pkg::ST_DIV: begin
				rem_q <= rem_n[31:0];
				sh_q  <= sh_q << 1;
				quo_q <= quo_n;
				cnt_q <= cnt_q + 1'b1;
				i0_q  <= quo_n[QW-1:16];
				f_q   <= quo_n[15:0];
			end
			adcm_pkg::ST_RD1:    t0_q <= ram_rdata;
			adcm_pkg::ST_RD2:    t1_q <= ram_rdata;
			adcm_pkg::ST_INTERP: c_q <= c_c;
			adcm_pkg::ST_GAIN:   p_q <= p_c;
			adcm_pkg::ST_CLAMP:  pu_q <= 44'(pr_c + 44'sd4398046511104);
			adcm_pkg::ST_MAP:    q_q <= q_c;
			adcm_pkg::ST_OUT: begin
				if (out_load) begin
					out_q <= o_sat;
				end
			end
			default: ;
		endcase
	end

	assign res_empty = !out_valid_q;
	assign axis_out  = out_q;

	adcm_ram #(
		.WIDTH(18),
		.DEPTH(TABLE_DEPTH)
	) u_curve (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_ext[IW-1:0]),
		.wdata(q_head.value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTH
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adcm_pkg::ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_div_operand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adcm_pkg::ST_TMUL) |-> (num_q > 38'sd0 && num_q < den_ext))
		else $error("division entered with magnitude outside open interval");

	a_lookup_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adcm_pkg::ST_RD1) |-> (i0_q <= LAST))
		else $error("curve index beyond table");
`endif

endmodule

>>> rtl/axis_deadzone_curve_mapper.sv
// Joystick axis shaper: smoothing, deadzone, response curve, gain, output mapping.
// Input channel (push/full): one beat is either an axis sample (kind 0) or a
// response table write (kind 1, table_index/table_value). Result channel
// (empty/pop): one axis_out beat per sample; table writes and samples taken
// while input_high <= input_low give nothing.
// Config: cfg_we/cfg_idx/cfg_wdata write one register per cycle; the user must
// write only while idle, as the block itself does not enforce it. A table write
// is done in the idle state; a sample with deadzone or full-scale magnitude
// skips the restoring divider, which otherwise yields one quotient bit a cycle.
// Once seeded, the filter adds its multiply, sum and rounding steps. One sample
// finishes before the next starts. A two-beat queue decouples intake from the
// sequencer, so push keeps being taken while a sample is in flight, until the
// queue is full; a one-beat result register holds the answer when pop is low,
// and the sequencer waits on it before taking more.
// Reset: registers to their defaults, filter unseeded, queue and result register
// empty. The curve table is not cleared and must be written before it is read.
module axis_deadzone_curve_mapper #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic signed [15:0] sample_value,
	input  logic [7:0]         table_index,
	input  logic signed [17:0] table_value,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] axis_out,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	adcm_pkg::cfg_t  cfg_q;
	adcm_pkg::item_t f_item;
	adcm_pkg::item_t q_head;
	logic            f_push;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;

	// register file; defaults give full-range identity mapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_low   <= -16'sd32768;
			cfg_q.input_high  <= 16'sd32767;
			cfg_q.output_low  <= -16'sd32768;
			cfg_q.output_high <= 16'sd32767;
			cfg_q.dead_band   <= 16'd0;
			cfg_q.gain        <= 16'd4096;
			cfg_q.smoothing   <= 16'd0;
			cfg_q.reverse     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				adcm_pkg::REG_INPUT_LOW:   cfg_q.input_low   <= cfg_wdata;
				adcm_pkg::REG_INPUT_HIGH:  cfg_q.input_high  <= cfg_wdata;
				adcm_pkg::REG_OUTPUT_LOW:  cfg_q.output_low  <= cfg_wdata;
				adcm_pkg::REG_OUTPUT_HIGH: cfg_q.output_high <= cfg_wdata;
				adcm_pkg::REG_DEAD_BAND:   cfg_q.dead_band   <= cfg_wdata;
				adcm_pkg::REG_GAIN:        cfg_q.gain        <= cfg_wdata;
				adcm_pkg::REG_SMOOTHING:   cfg_q.smoothing   <= cfg_wdata;
				adcm_pkg::REG_REVERSE:     cfg_q.reverse     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// intake: classify beat, drop samples for an empty input range
	adcm_front u_front (
		.push        (push),
		.full        (full),
		.kind        (kind),
		.sample_value(sample_value),
		.table_index (table_index),
		.table_value (table_value),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.q_push      (f_push),
		.q_item      (f_item)
	);

	adcm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_item(f_item),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// sequencer: filter, divider, table lookup, mapping, result register
	adcm_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.res_empty(empty),
		.res_pop  (pop),
		.axis_out (axis_out)
	);

endmodule
